// ===== design/gva_pkg.sv =====
// ----------------------------------------------------------------------------
// gva_pkg
// types, constants and helpers shared by the velocity accumulator
// ----------------------------------------------------------------------------
package gva_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int ALU_W         = 128;
    localparam int CNT_W         = 7;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(32);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ALU_W - 1);

    localparam logic [2:0] CFG_OWN_POS_X = 3'd0;
    localparam logic [2:0] CFG_OWN_POS_Y = 3'd1;
    localparam logic [2:0] CFG_OWN_MASS  = 3'd2;
    localparam logic [2:0] CFG_GRAVITY   = 3'd3;
    localparam logic [2:0] CFG_TIME_STEP = 3'd4;

    localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        FAULT_OK        = 2'd0,
        FAULT_ZERO_DIST = 2'd1,
        FAULT_MASS_ZERO = 2'd2,
        FAULT_SAT       = 2'd3
    } t_fault;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SQX, PH_SQY, PH_SSUM, PH_SQRT, PH_DEN, PH_GM,
        PH_PROD, PH_NUMX, PH_DIVX, PH_NUMY, PH_DIVY, PH_FIN
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   last;
    } t_ctrl;

    // returns {saturated, new value}
    function automatic logic [32:0] sat_add(input logic [31:0] v, input logic neg,
                                            input logic [33:0] mag, input logic big);
        logic signed [35:0] s;
        logic [32:0]        res;
        s = $signed({{4{v[31]}}, v});
        if (neg) s = s - $signed({2'b00, mag});
        else s = s + $signed({2'b00, mag});
        if (big) res = {1'b1, (neg ? VEL_MIN : VEL_MAX)};
        else if (s > $signed(36'h0_7FFF_FFFF)) res = {1'b1, VEL_MAX};
        else if (s < $signed(36'hF_8000_0000)) res = {1'b1, VEL_MIN};
        else res = {1'b0, s[31:0]};
        return res;
    endfunction

endpackage

// ===== design/gva_alu.sv =====
// ----------------------------------------------------------------------------
// gva_alu
// shared add / subtract unit, carry out doubles as a >= compare
// ----------------------------------------------------------------------------
module gva_alu #(
    parameter int W = gva_pkg::ALU_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (W+1)'(i_sub);
endmodule

// ===== design/gva_ctrl.sv =====
// ----------------------------------------------------------------------------
// gva_ctrl
// phase sequencer with step counter for the shared unit
// ----------------------------------------------------------------------------
module gva_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_grav,
    input  logic           i_fin_ok,
    output gva_pkg::t_ctrl o_ctrl
);
    import gva_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] lim;
    logic             last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_SQX, PH_SQY, PH_SQRT, PH_DEN, PH_GM, PH_PROD, PH_NUMX, PH_NUMY:
                lim = MUL_LAST;
            PH_DIVX, PH_DIVY: lim = DIV_LAST;
            default: lim = '0;
        endcase
        last    = (r_cnt == lim);
        n_phase = r_phase;
        n_cnt   = last ? '0 : r_cnt + CNT_W'(1);
        unique case (r_phase)
            PH_IDLE: begin
                n_cnt = '0;
                if (i_start) n_phase = i_grav ? PH_SQX : PH_FIN;
            end
            PH_SQX:  if (last) n_phase = PH_SQY;
            PH_SQY:  if (last) n_phase = PH_SSUM;
            PH_SSUM: n_phase = PH_SQRT;
            PH_SQRT: if (last) n_phase = PH_DEN;
            PH_DEN:  if (last) n_phase = PH_GM;
            PH_GM:   if (last) n_phase = PH_PROD;
            PH_PROD: if (last) n_phase = PH_NUMX;
            PH_NUMX: if (last) n_phase = PH_DIVX;
            PH_DIVX: if (last) n_phase = PH_NUMY;
            PH_NUMY: if (last) n_phase = PH_DIVY;
            PH_DIVY: if (last) n_phase = PH_FIN;
            PH_FIN: begin
                n_cnt = '0;
                if (i_fin_ok) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
        o_ctrl.phase = r_phase;
        o_ctrl.last  = last;
    end
endmodule

// ===== design/gravity_velocity_accumulator.sv =====
// ----------------------------------------------------------------------------
// gravity_velocity_accumulator
// one body's 2-D velocity, updated by gravity pulls and impulses
// ----------------------------------------------------------------------------
// In a gravity beat every product, the square root and both divisions run one
// bit or digit per cycle through a single shared 128-bit adder (eight 33-step
// multiply or root passes, one sum step, two 128-step divisions and the final
// saturating update). Impulse, self and fault beats skip the arithmetic and go
// straight to the final saturating update. One beat is worked on at a time and
// the block is ready again as soon as the result is written, so a new beat is
// taken only once the last one is through; a result held back by the sink
// stalls the final step. A finished result waits in the output register while
// the next beat is accepted.
module gravity_velocity_accumulator #(
    parameter int POS_WIDTH = gva_pkg::POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_is_self,
    input  logic [31:0] i_body_x,
    input  logic [31:0] i_body_y,
    input  logic [31:0] i_body_mass,
    input  logic [31:0] i_impulse_x,
    input  logic [31:0] i_impulse_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_velocity_x,
    output logic [31:0] o_velocity_y,
    output logic [1:0]  o_fault,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import gva_pkg::*;

    localparam int PW = (POS_WIDTH < 16) ? 16 : ((POS_WIDTH > 32) ? 32 : POS_WIDTH);
    localparam int SH = 32 - PW;

    logic [31:0] r_own_x, r_own_y, r_own_mass, r_gconst, r_dt;
    logic [31:0] r_vel_x, r_vel_y;
    t_fault      r_fault;
    logic        r_out_valid;

    t_ctrl       ctrl;
    logic        accept, grav, fin_ok, fin_fire;

    logic [32:0]  r_ax, r_ay, r_mplr, r_root;
    logic         r_negx, r_negy;
    logic [31:0]  r_bmass;
    logic [127:0] r_acc, r_num;
    logic [65:0]  r_s;
    logic [106:0] r_rem, r_den;
    logic [95:0]  r_p;
    logic [33:0]  r_q, r_magx, r_magy;
    logic         r_ovf, r_bigx, r_bigy;
    t_fault       r_pre;

    logic signed [31:0] bx, by, ox, oy;
    logic signed [32:0] dx, dy;
    logic [32:0]  ax, ay, imx, imy;
    logic [127:0] acc_sh, mcand, alu_a, alu_b, alu_sum;
    logic         alu_sub, alu_carry;
    logic [35:0]  sq_rem_sh;
    logic [107:0] dv_rem_sh;
    logic [33:0]  n_q;
    logic         n_ovf;
    logic [32:0]  satx, saty;

    assign o_ready      = (ctrl.phase == PH_IDLE);
    assign accept       = i_valid && o_ready;
    assign fin_ok       = !r_out_valid || i_ready;
    assign fin_fire     = (ctrl.phase == PH_FIN) && fin_ok;
    assign o_valid      = r_out_valid;
    assign o_velocity_x = r_vel_x;
    assign o_velocity_y = r_vel_y;
    assign o_fault      = r_fault;

    assign bx  = $signed(i_body_x << SH) >>> SH;
    assign by  = $signed(i_body_y << SH) >>> SH;
    assign ox  = $signed(r_own_x << SH) >>> SH;
    assign oy  = $signed(r_own_y << SH) >>> SH;
    assign dx  = 33'(bx) - 33'(ox);
    assign dy  = 33'(by) - 33'(oy);
    assign ax  = dx[32] ? 33'(0) - dx : dx;
    assign ay  = dy[32] ? 33'(0) - dy : dy;
    assign imx = i_impulse_x[31] ? 33'(0) - {1'b1, i_impulse_x} : {1'b0, i_impulse_x};
    assign imy = i_impulse_y[31] ? 33'(0) - {1'b1, i_impulse_y} : {1'b0, i_impulse_y};
    assign grav = !i_func && !i_is_self && (r_own_mass != '0) && (dx != '0 || dy != '0);

    gva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_grav   (grav),
        .i_fin_ok (fin_ok),
        .o_ctrl   (ctrl)
    );

    gva_alu #(.W(ALU_W)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_comb begin
        acc_sh    = {r_acc[126:0], 1'b0};
        sq_rem_sh = {r_rem[33:0], r_acc[65:64]};
        dv_rem_sh = {r_rem, r_num[127]};
        unique case (ctrl.phase)
            PH_SQX:           mcand = 128'(r_ax);
            PH_SQY:           mcand = 128'(r_ay);
            PH_DEN:           mcand = 128'(r_s);
            PH_GM:            mcand = 128'(r_gconst);
            PH_PROD:          mcand = 128'(r_p[63:0]);
            PH_NUMX, PH_NUMY: mcand = 128'(r_p);
            default:          mcand = '0;
        endcase
        alu_a   = acc_sh;
        alu_b   = r_mplr[32] ? mcand : '0;
        alu_sub = 1'b0;
        unique case (ctrl.phase)
            PH_SSUM: begin
                alu_a = 128'(r_s);
                alu_b = r_acc;
            end
            PH_SQRT: begin
                alu_a   = 128'(sq_rem_sh);
                alu_b   = 128'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            PH_DIVX, PH_DIVY: begin
                alu_a   = 128'(dv_rem_sh);
                alu_b   = 128'(r_den);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
        n_q   = {r_q[32:0], alu_carry};
        n_ovf = r_ovf | r_q[33];
        satx  = sat_add(r_vel_x, r_negx, r_magx, r_bigx);
        saty  = sat_add(r_vel_y, r_negy, r_magy, r_bigy);
    end

    // config, velocity state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x     <= '0;
            r_own_y     <= '0;
            r_own_mass  <= 32'd256;
            r_gconst    <= 32'd16777216;
            r_dt        <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_fault     <= FAULT_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OWN_POS_X: r_own_x    <= i_cfg_data;
                    CFG_OWN_POS_Y: r_own_y    <= i_cfg_data;
                    CFG_OWN_MASS:  r_own_mass <= i_cfg_data;
                    CFG_GRAVITY:   r_gconst   <= i_cfg_data;
                    CFG_TIME_STEP: r_dt       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (fin_fire) begin
                r_vel_x     <= satx[31:0];
                r_vel_y     <= saty[31:0];
                r_fault     <= (r_pre != FAULT_OK) ? r_pre :
                               ((satx[32] || saty[32]) ? FAULT_SAT : FAULT_OK);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax    <= ax;
            r_ay    <= ay;
            r_bmass <= i_body_mass;
            r_acc   <= '0;
            r_mplr  <= ax;
            r_bigx  <= 1'b0;
            r_bigy  <= 1'b0;
            if (i_func) begin
                r_negx <= i_impulse_x[31];
                r_negy <= i_impulse_y[31];
                r_magx <= 34'(imx);
                r_magy <= 34'(imy);
                r_pre  <= FAULT_OK;
            end else begin
                r_negx <= dx[32];
                r_negy <= dy[32];
                r_magx <= '0;
                r_magy <= '0;
                if (i_is_self) r_pre <= FAULT_OK;
                else if (r_own_mass == '0) r_pre <= FAULT_MASS_ZERO;
                else if (dx == '0 && dy == '0) r_pre <= FAULT_ZERO_DIST;
                else r_pre <= FAULT_OK;
            end
        end else begin
            unique case (ctrl.phase)
                PH_SQX, PH_SQY, PH_DEN, PH_GM, PH_PROD, PH_NUMX, PH_NUMY: begin
                    r_acc  <= alu_sum;
                    r_mplr <= {r_mplr[31:0], 1'b0};
                    if (ctrl.last) begin
                        r_acc <= '0;
                        unique case (ctrl.phase)
                            PH_SQX: begin
                                r_s    <= alu_sum[65:0];
                                r_mplr <= r_ay;
                            end
                            PH_SQY: r_acc <= alu_sum;
                            PH_DEN: begin
                                r_den  <= {alu_sum[98:0], 8'b0};
                                r_mplr <= {1'b0, r_bmass};
                            end
                            PH_GM: begin
                                r_p    <= alu_sum[95:0];
                                r_mplr <= {1'b0, r_dt};
                            end
                            PH_PROD: begin
                                r_p    <= alu_sum[95:0];
                                r_mplr <= r_ax;
                            end
                            default: begin
                                r_num <= alu_sum;
                                r_rem <= '0;
                                r_q   <= '0;
                                r_ovf <= 1'b0;
                            end
                        endcase
                    end
                end
                PH_SSUM: begin
                    r_s    <= alu_sum[65:0];
                    r_acc  <= alu_sum;
                    r_rem  <= '0;
                    r_root <= '0;
                end
                PH_SQRT: begin
                    r_rem  <= alu_carry ? 107'(alu_sum[35:0]) : 107'(sq_rem_sh);
                    r_root <= {r_root[31:0], alu_carry};
                    r_acc  <= {r_acc[125:0], 2'b00};
                    if (ctrl.last) begin
                        r_acc  <= '0;
                        r_mplr <= {r_root[31:0], alu_carry};
                    end
                end
                PH_DIVX, PH_DIVY: begin
                    r_rem <= alu_carry ? alu_sum[106:0] : dv_rem_sh[106:0];
                    r_num <= {r_num[126:0], 1'b0};
                    r_q   <= n_q;
                    r_ovf <= n_ovf;
                    if (ctrl.last) begin
                        if (ctrl.phase == PH_DIVX) begin
                            r_magx <= n_q;
                            r_bigx <= n_ovf;
                            r_acc  <= '0;
                            r_mplr <= r_ay;
                        end else begin
                            r_magy <= n_q;
                            r_bigy <= n_ovf;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("block ready right after taking a beat");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.phase == PH_DIVX || ctrl.phase == PH_DIVY) |-> (r_den != '0))
        else $error("division by zero denominator");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fault == FAULT_SAT) |->
        (r_vel_x == VEL_MAX || r_vel_x == VEL_MIN ||
         r_vel_y == VEL_MAX || r_vel_y == VEL_MIN))
        else $error("saturation flagged without a clamped velocity");

endmodule
